[hdl/rgbwb_pkg.sv]
`default_nettype none

package rgbwb_pkg;

  localparam int unsigned SAMPLE_BITS_DEF  = 16;
  localparam int unsigned FRAC_BITS_DEF    = 16;
  localparam int unsigned PIX_W            = 16;
  localparam int unsigned CFG_W            = 17;
  localparam int unsigned DEPTH_W          = 5;
  localparam int unsigned APB_DW           = 32;
  localparam int unsigned APB_AW           = 5;
  localparam int unsigned SCALE_INT_BITS   = 20;
  localparam int unsigned Q16_SHIFT        = 16;
  localparam int unsigned BLEND_SHIFT_BASE = 32;

  localparam logic [CFG_W-1:0]   Q16_ONE     = 17'h10000;
  localparam logic [CFG_W-1:0]   Q16_ZERO    = 17'h00000;
  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 5'd8;

  typedef enum logic [2:0] {
    REG_GAIN_RED   = 3'd0,
    REG_GAIN_GREEN = 3'd1,
    REG_GAIN_BLUE  = 3'd2,
    REG_MIX        = 3'd3,
    REG_PRESERVE   = 3'd4,
    REG_DEPTH      = 3'd5
  } cfg_reg_e;

endpackage

`default_nettype wire

[hdl/rgbwb_if.sv]
`default_nettype none

interface rgbwb_in_if import rgbwb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red_in;
  logic [PIX_W-1:0] green_in;
  logic [PIX_W-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in, input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

interface rgbwb_out_if import rgbwb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red_out;
  logic [PIX_W-1:0] green_out;
  logic [PIX_W-1:0] blue_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  output ready);
endinterface

`default_nettype wire

[hdl/rgb_white_balance_pixel.sv]
// Throughput: one pixel per clock while the output takes beats; the lightness divider
//   resolves one quotient bit per stage, which sets the pipeline depth.
// A stalled output holds its beat; empty stages ahead of it still take new beats.
// Reset (rst_ni low, asynchronous) clears all valid bits and loads the register defaults.
`default_nettype none

module rgb_white_balance_pixel import rgbwb_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rgbwb_in_if.sink          pix_in_i,
  rgbwb_out_if.source       pix_out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned XW    = SAMPLE_BITS;
  localparam int unsigned F     = FRAC_BITS;
  localparam int unsigned L0W   = XW + 1;
  localparam int unsigned P1W   = XW + 19;
  localparam int unsigned M2W   = P1W + 18;
  localparam int unsigned BW    = XW + F + 3;
  localparam int unsigned MAGW  = BW - 1;
  localparam int unsigned DW    = BW;
  localparam int unsigned PW    = MAGW + L0W;
  localparam int unsigned QW    = SCALE_INT_BITS + F;
  localparam int unsigned SDW   = QW + 2;
  localparam int unsigned PMW   = SDW + 18;
  localparam int unsigned FW    = QW + 4;
  localparam int unsigned VW    = FW - F;
  localparam int unsigned BSH   = BLEND_SHIFT_BASE - F;
  localparam int unsigned SW    = 3 * (BW + 2) + 1;
  localparam int unsigned K_DIV = 6;
  localparam int unsigned K_F1  = K_DIV + QW;
  localparam int unsigned K_F2  = K_F1 + 1;
  localparam int unsigned NST   = K_F2 + 2;

  // configuration registers
  logic [CFG_W-1:0]   gain_q [3];
  logic [CFG_W-1:0]   mix_q;
  logic [CFG_W-1:0]   pres_q;
  logic [DEPTH_W-1:0] depth_q;
  logic               cfg_wr;
  cfg_reg_e           cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_e'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q[0] <= Q16_ONE;
      gain_q[1] <= Q16_ONE;
      gain_q[2] <= Q16_ONE;
      mix_q     <= Q16_ONE;
      pres_q    <= Q16_ZERO;
      depth_q   <= DEPTH_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_GAIN_RED:   gain_q[0] <= pwdata[CFG_W-1:0];
        REG_GAIN_GREEN: gain_q[1] <= pwdata[CFG_W-1:0];
        REG_GAIN_BLUE:  gain_q[2] <= pwdata[CFG_W-1:0];
        REG_MIX:        mix_q     <= pwdata[CFG_W-1:0];
        REG_PRESERVE:   pres_q    <= pwdata[CFG_W-1:0];
        REG_DEPTH:      depth_q   <= pwdata[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_GAIN_RED:   prdata = APB_DW'(gain_q[0]);
      REG_GAIN_GREEN: prdata = APB_DW'(gain_q[1]);
      REG_GAIN_BLUE:  prdata = APB_DW'(gain_q[2]);
      REG_MIX:        prdata = APB_DW'(mix_q);
      REG_PRESERVE:   prdata = APB_DW'(pres_q);
      REG_DEPTH:      prdata = APB_DW'(depth_q);
      default:        prdata = '0;
    endcase
  end

  // clip limit
  logic [DEPTH_W-1:0] dep_eff;
  logic [XW-1:0]      top;

  assign dep_eff = (depth_q > DEPTH_W'(XW)) ? DEPTH_W'(XW) : depth_q;
  assign top     = XW'(((XW+1)'(1) << dep_eff) - (XW+1)'(1));

  // valid bits and stall handling
  logic [NST-1:0] v_q;
  logic [NST-1:0] v_d;
  logic [NST-1:0] v_in;
  logic [NST-1:0] en;

  for (genvar k = 0; k < NST; k++) begin : g_en
    assign en[k] = pix_out_o.ready || !(&v_q[NST-1:k]);
  end

  assign v_in = {v_q[NST-2:0], pix_in_i.valid};

  always_comb begin
    for (int k = 0; k < NST; k++) begin
      v_d[k] = en[k] ? v_in[k] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign pix_in_i.ready  = en[0];
  assign pix_out_o.valid = v_q[NST-1];

  // stage 0: gain offset product, input lightness
  logic [XW-1:0]         xin [3];
  logic signed [P1W-1:0] p1_d [3];
  logic signed [P1W-1:0] p1_q [3];
  logic [XW-1:0]         x0_q [3];
  logic [L0W-1:0]        l0_d;
  logic [L0W-1:0]        l00_q;

  assign xin[0] = pix_in_i.red_in[XW-1:0];
  assign xin[1] = pix_in_i.green_in[XW-1:0];
  assign xin[2] = pix_in_i.blue_in[XW-1:0];

  always_comb begin
    logic [XW-1:0]      mx;
    logic [XW-1:0]      mn;
    logic signed [17:0] g1;
    for (int c = 0; c < 3; c++) begin
      g1      = $signed({1'b0, gain_q[c]}) - $signed({1'b0, Q16_ONE});
      p1_d[c] = P1W'($signed({1'b0, xin[c]})) * P1W'(g1);
    end
    mx = xin[0];
    mn = xin[0];
    for (int c = 1; c < 3; c++) begin
      if (xin[c] > mx) mx = xin[c];
      if (xin[c] < mn) mn = xin[c];
    end
    l0_d = L0W'(mx) + L0W'(mn);
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      p1_q  <= p1_d;
      x0_q  <= xin;
      l00_q <= l0_d;
    end
  end

  // stage 1: mix product
  logic signed [M2W-1:0] m2_d [3];
  logic signed [M2W-1:0] m2_q [3];
  logic [XW-1:0]         x1_q [3];
  logic [L0W-1:0]        l01_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      m2_d[c] = M2W'(p1_q[c]) * M2W'($signed({1'b0, mix_q}));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      m2_q  <= m2_d;
      x1_q  <= x0_q;
      l01_q <= l00_q;
    end
  end

  // stage 2: blended sample
  logic signed [BW-1:0] b2_d [3];
  logic signed [BW-1:0] b2_q [3];
  logic [L0W-1:0]       l02_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      b2_d[c] = BW'(m2_q[c] >>> BSH) + BW'({x1_q[c], {F{1'b0}}});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      b2_q  <= b2_d;
      l02_q <= l01_q;
    end
  end

  // stage 3: blended lightness, magnitudes
  logic signed [BW:0]   l1_d;
  logic signed [BW:0]   l1_q;
  logic [MAGW-1:0]      mag_d [3];
  logic [MAGW-1:0]      mag3_q [3];
  logic signed [BW-1:0] b3_q [3];
  logic [L0W-1:0]       l03_q;

  always_comb begin
    logic signed [BW-1:0] bmx;
    logic signed [BW-1:0] bmn;
    bmx = b2_q[0];
    bmn = b2_q[0];
    for (int c = 1; c < 3; c++) begin
      if (b2_q[c] > bmx) bmx = b2_q[c];
      if (b2_q[c] < bmn) bmn = b2_q[c];
    end
    l1_d = (BW+1)'(bmx) + (BW+1)'(bmn);
    for (int c = 0; c < 3; c++) begin
      mag_d[c] = MAGW'(b2_q[c][BW-1] ? -b2_q[c] : b2_q[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      l1_q   <= l1_d;
      mag3_q <= mag_d;
      b3_q   <= b2_q;
      l03_q  <= l02_q;
    end
  end

  // stage 4: divisor, numerator product
  logic [DW-1:0]        d4_q;
  logic                 zero4_q;
  logic                 neg4_q [3];
  logic [PW-1:0]        p4_d [3];
  logic [PW-1:0]        p4_q [3];
  logic signed [BW-1:0] b4_q [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      p4_d[c] = PW'(mag3_q[c]) * PW'(l03_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      d4_q    <= DW'(l1_q[BW] ? -l1_q : l1_q);
      zero4_q <= (l1_q == '0);
      for (int c = 0; c < 3; c++) begin
        neg4_q[c] <= b3_q[c][BW-1] ^ l1_q[BW];
      end
      p4_q <= p4_d;
      b4_q <= b3_q;
    end
  end

  // stage 5: saturation check, divider seed
  logic [DW-1:0]      d5_q;
  logic [2:0][DW-1:0] rem5_q;
  logic [2:0][QW-1:0] work5_q;
  logic [SW-1:0]      side5_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      d5_q <= d4_q;
      side5_q[SW-1] <= zero4_q;
      for (int c = 0; c < 3; c++) begin
        rem5_q[c]  <= DW'(p4_q[c] >> SCALE_INT_BITS);
        work5_q[c] <= {p4_q[c][SCALE_INT_BITS-1:0], {F{1'b0}}};
        side5_q[c*(BW+2) +: BW+2] <=
          {b4_q[c], neg4_q[c], ((p4_q[c] >> SCALE_INT_BITS) >= PW'(d4_q))};
      end
    end
  end

  // lightness ratio divider
  logic [2:0][QW-1:0] quo;
  logic [SW-1:0]      side6;

  rgbwb_div #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .adv_i  (en[K_DIV +: QW]),
    .den_i  (d5_q),
    .rem_i  (rem5_q),
    .work_i (work5_q),
    .side_i (side5_q),
    .quo_o  (quo),
    .side_o (side6)
  );

  // fin stage 1: signed scaled sample minus blended sample
  logic signed [SDW-1:0] sd_d [3];
  logic signed [SDW-1:0] sd_q [3];
  logic signed [BW-1:0]  bq [3];
  logic signed [BW-1:0]  b7_q [3];

  always_comb begin
    logic [QW-1:0]   qmag;
    logic signed [QW:0] s;
    for (int c = 0; c < 3; c++) begin
      bq[c] = $signed(side6[c*(BW+2)+2 +: BW]);
      if (side6[SW-1]) begin
        qmag = '0;
      end else if (side6[c*(BW+2)]) begin
        qmag = '1;
      end else begin
        qmag = quo[c];
      end
      s = side6[c*(BW+2)+1] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
      sd_d[c] = SDW'(s) - SDW'(bq[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[K_F1]) begin
      sd_q <= sd_d;
      b7_q <= bq;
    end
  end

  // fin stage 2: preserve product
  logic signed [PMW-1:0] pm_d [3];
  logic signed [PMW-1:0] pm_q [3];
  logic signed [BW-1:0]  b8_q [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      pm_d[c] = PMW'(sd_q[c]) * PMW'($signed({1'b0, pres_q}));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[K_F2]) begin
      pm_q <= pm_d;
      b8_q <= b7_q;
    end
  end

  // output stage: final sum, floor, clip
  logic [PIX_W-1:0] out_d [3];
  logic [PIX_W-1:0] out_q [3];

  always_comb begin
    logic signed [PMW-1:0] t;
    logic signed [FW-1:0]  f;
    logic [VW-1:0]         vu;
    for (int c = 0; c < 3; c++) begin
      t  = pm_q[c] >>> Q16_SHIFT;
      f  = FW'(b8_q[c]) + FW'(t);
      vu = f[FW-1:F];
      if (f[FW-1]) begin
        out_d[c] = '0;
      end else if (vu > VW'(top)) begin
        out_d[c] = PIX_W'(top);
      end else begin
        out_d[c] = PIX_W'(vu[XW-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NST-1]) begin
      out_q <= out_d;
    end
  end

  assign pix_out_o.red_out   = out_q[0];
  assign pix_out_o.green_out = out_q[1];
  assign pix_out_o.blue_out  = out_q[2];

`ifndef ASSERT_OFF
  a_blocked_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_in_i.ready |-> ((&v_q) && !pix_out_o.ready))
    else $error("input blocked while pipeline has a free stage");

  a_beat_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> ($countones(v_q) == $past($countones(v_q))
      + $past(pix_in_i.valid && pix_in_i.ready)
      - $past(pix_out_o.valid && pix_out_o.ready)))
    else $error("beat lost or duplicated in pipeline");

  a_out_from_prev_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_out_o.valid && !$past(pix_out_o.valid)) |-> $past(v_q[NST-2]))
    else $error("output beat without a beat in the stage before");
`endif

endmodule

`default_nettype wire

[hdl/rgbwb_div.sv]
`default_nettype none

module rgbwb_div import rgbwb_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF,
  localparam int unsigned BW = SAMPLE_BITS + FRAC_BITS + 3,
  localparam int unsigned DW = BW,
  localparam int unsigned QW = SCALE_INT_BITS + FRAC_BITS,
  localparam int unsigned SW = 3 * (BW + 2) + 1
) (
  input  logic                   clk_i,
  input  logic [QW-1:0]          adv_i,
  input  logic [DW-1:0]          den_i,
  input  logic [2:0][DW-1:0]     rem_i,
  input  logic [2:0][QW-1:0]     work_i,
  input  logic [SW-1:0]          side_i,
  output logic [2:0][QW-1:0]     quo_o,
  output logic [SW-1:0]          side_o
);

  logic [DW-1:0]      den_q  [QW];
  logic [2:0][DW-1:0] rem_q  [QW];
  logic [2:0][QW-1:0] work_q [QW];
  logic [SW-1:0]      side_q [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [DW-1:0]      den_in;
    logic [2:0][DW-1:0] rem_in;
    logic [2:0][QW-1:0] work_in;
    logic [SW-1:0]      side_in;
    logic [2:0][DW-1:0] rem_d;
    logic [2:0][QW-1:0] work_d;

    if (j == 0) begin : g_first
      assign den_in  = den_i;
      assign rem_in  = rem_i;
      assign work_in = work_i;
      assign side_in = side_i;
    end else begin : g_next
      assign den_in  = den_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign work_in = work_q[j-1];
      assign side_in = side_q[j-1];
    end

    always_comb begin
      logic [DW:0] sh;
      logic        ge;
      for (int c = 0; c < 3; c++) begin
        sh = {rem_in[c], work_in[c][QW-1]};
        ge = (sh >= {1'b0, den_in});
        rem_d[c]  = ge ? DW'(sh - {1'b0, den_in}) : DW'(sh);
        work_d[c] = {work_in[c][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i[j]) begin
        den_q[j]  <= den_in;
        rem_q[j]  <= rem_d;
        work_q[j] <= work_d;
        side_q[j] <= side_in;
      end
    end
  end

  assign quo_o  = work_q[QW-1];
  assign side_o = side_q[QW-1];

endmodule

`default_nettype wire
